[rtl/pulse_channel_sweep_envelope_assert.svh]
// assertion macros for the pulse channel block
// no dependencies; included by the top level only
`ifndef PULSE_CHANNEL_SWEEP_ENVELOPE_ASSERT_SVH
`define PULSE_CHANNEL_SWEEP_ENVELOPE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PCSE_ASSERT_SAME(label, clk, rst, cond, concl) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (concl)) \
      else $error("pcse assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define PCSE_ASSERT_NEXT(label, clk, rst, cond, concl) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (concl)) \
      else $error("pcse assertion failed: next-cycle implication");

`endif

[rtl/pcse_pkg.sv]
// shared types and constants for the pulse channel with sweep and envelope
// no dependencies
package pcse_pkg;

   typedef enum logic [2:0] {
      FUNC_TICK   = 3'd0,
      FUNC_LENGTH = 3'd1,
      FUNC_SWEEP  = 3'd2,
      FUNC_ENV    = 3'd3,
      FUNC_WRITE  = 3'd4,
      FUNC_READ   = 3'd5,
      FUNC_POWER  = 3'd6
   } func_code_type;

   localparam logic [15:0] ADDR_NR10 = 16'hff10;
   localparam logic [15:0] ADDR_NR11 = 16'hff11;
   localparam logic [15:0] ADDR_NR12 = 16'hff12;
   localparam logic [15:0] ADDR_NR13 = 16'hff13;
   localparam logic [15:0] ADDR_NR14 = 16'hff14;

   localparam logic [11:0] FREQ_SPAN = 12'd2048;
   localparam logic [6:0]  LEN_FULL  = 7'd64;
   localparam logic [7:0]  READ_NONE = 8'hff;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic        frame_odd;
      logic        init_length;
   } req_type;

   typedef struct packed {
      logic [3:0] sample;
      logic [7:0] rdata;
      logic       channel_on;
   } rsp_type;

   typedef struct packed {
      logic        chan_enable;
      logic [2:0]  sweep_time;
      logic        sweep_down;
      logic [2:0]  sweep_step;
      logic        negate_used;
      logic [1:0]  duty_sel;
      logic [6:0]  length_left;
      logic [3:0]  env_start;
      logic        env_up;
      logic [2:0]  env_pace;
      logic [10:0] tone_freq;
      logic        length_on;
      logic [3:0]  level_out;
      logic        wave_high;
      logic [2:0]  duty_phase;
      logic [12:0] period_count;
      logic [2:0]  env_count;
      logic [2:0]  sweep_count;
      logic [10:0] shadow_freq;
      logic        sweep_active;
      logic [3:0]  cur_volume;
   } chan_state_type;

endpackage

[rtl/pcse_core.sv]
// channel state registers and the per-transaction event logic
// depends on pcse_pkg
module pcse_core import pcse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    item_accept,
   input  req_type item,
   output rsp_type result
);

   chan_state_type state_ff, state_in;
   logic [7:0]     rdata;

   function automatic logic [12:0] reload_period(input logic [10:0] f);
      logic [11:0] span;
      span = FREQ_SPAN - {1'b0, f};
      return {span, 1'b0};
   endfunction

   function automatic chan_state_type sweep_calc(input chan_state_type s, input logic apply);
      chan_state_type r;
      logic [11:0]    delta;
      logic [11:0]    nf;
      r = s;
      delta = {1'b0, s.shadow_freq >> s.sweep_step};
      nf = s.sweep_down ? ({1'b0, s.shadow_freq} - delta) : ({1'b0, s.shadow_freq} + delta);
      if (s.sweep_active) begin
         r.negate_used = s.sweep_down;
         if (nf[11]) begin
            r.chan_enable = 1'b0;
         end else if (s.sweep_step != 3'd0 && apply) begin
            r.shadow_freq  = nf[10:0];
            r.tone_freq    = nf[10:0];
            r.period_count = reload_period(nf[10:0]);
         end
      end
      return r;
   endfunction

   function automatic chan_state_type power_clear(input chan_state_type s, input logic init_len);
      chan_state_type r;
      r = '0;
      r.length_left = init_len ? LEN_FULL : s.length_left;
      return r;
   endfunction

   always_comb begin
      chan_state_type s;
      logic           dac;
      logic           len_bit;
      s = state_ff;
      rdata = READ_NONE;
      dac = 1'b0;
      len_bit = 1'b0;
      unique case (func_code_type'(item.func))
         FUNC_TICK: begin
            if (s.period_count != 13'd0) begin
               s.period_count = s.period_count - 13'd1;
               if (s.period_count == 13'd0) begin
                  s.period_count = reload_period(s.tone_freq);
                  s.duty_phase = s.duty_phase + 3'd1;
                  unique case (s.duty_sel)
                     2'd0: s.wave_high = (s.duty_phase == 3'd6);
                     2'd1: s.wave_high = (s.duty_phase >= 3'd6);
                     2'd2: s.wave_high = (s.duty_phase >= 3'd4);
                     2'd3: s.wave_high = (s.duty_phase <= 3'd5);
                  endcase
               end
            end
            s.level_out = (s.wave_high && s.chan_enable) ? s.cur_volume : 4'd0;
         end
         FUNC_LENGTH: begin
            if (s.length_on && s.length_left != 7'd0) begin
               s.length_left = s.length_left - 7'd1;
               if (s.length_left == 7'd0) s.chan_enable = 1'b0;
            end
         end
         FUNC_SWEEP: begin
            s.sweep_count = s.sweep_count - 3'd1;
            if (s.sweep_count == 3'd0) begin
               s.sweep_count = s.sweep_time;
               if (s.sweep_active && s.sweep_time != 3'd0) begin
                  s = sweep_calc(s, 1'b1);
                  s = sweep_calc(s, 1'b0);
               end
            end
         end
         FUNC_ENV: begin
            if (s.chan_enable && s.env_pace != 3'd0) begin
               s.env_count = s.env_count - 3'd1;
               if (s.env_count == 3'd0) begin
                  s.env_count = s.env_pace;
                  if (!s.env_up && s.cur_volume != 4'd0) s.cur_volume = s.cur_volume - 4'd1;
                  if (s.env_up && s.cur_volume != 4'd15) s.cur_volume = s.cur_volume + 4'd1;
               end
            end
         end
         FUNC_WRITE: begin
            if (item.addr == ADDR_NR10) begin
               // negate quirk: leaving subtract mode after it was used
               if (s.sweep_active && s.negate_used && !item.wdata[3]) s.chan_enable = 1'b0;
               s.sweep_time = item.wdata[6:4];
               s.sweep_down = item.wdata[3];
               s.sweep_step = item.wdata[2:0];
            end else if (item.addr == ADDR_NR11) begin
               s.duty_sel = item.wdata[7:6];
               s.length_left = LEN_FULL - {1'b0, item.wdata[5:0]};
            end else if (item.addr == ADDR_NR12) begin
               s.env_start = item.wdata[7:4];
               s.env_up = item.wdata[3];
               s.env_pace = item.wdata[2:0];
               if (s.env_start == 4'd0 && !s.env_up) s.chan_enable = 1'b0;
            end else if (item.addr == ADDR_NR13) begin
               s.tone_freq[7:0] = item.wdata;
            end else if (item.addr == ADDR_NR14) begin
               len_bit = item.wdata[6];
               // extra length clock when enabling on an odd frame step
               if (item.frame_odd && !s.length_on && len_bit && s.length_left != 7'd0) begin
                  s.length_left = s.length_left - 7'd1;
                  if (s.length_left == 7'd0) s.chan_enable = 1'b0;
               end
               s.length_on = len_bit;
               s.tone_freq[10:8] = item.wdata[2:0];
               if (item.wdata[7]) begin
                  dac = (s.env_start != 4'd0) || s.env_up;
                  s.chan_enable = dac;
                  s.period_count = reload_period(s.tone_freq);
                  s.env_count = s.env_pace;
                  s.cur_volume = s.env_start;
                  if (s.length_left == 7'd0) begin
                     s.length_left = (item.frame_odd && s.length_on) ?
                                     (LEN_FULL - 7'd1) : LEN_FULL;
                  end
                  s.shadow_freq = s.tone_freq;
                  s.negate_used = 1'b0;
                  s.sweep_count = s.sweep_time;
                  s.sweep_active = (s.sweep_time != 3'd0) || (s.sweep_step != 3'd0);
                  if (s.sweep_step != 3'd0) s = sweep_calc(s, 1'b0);
               end
            end
         end
         FUNC_READ: begin
            if (item.addr == ADDR_NR10) begin
               rdata = {1'b1, s.sweep_time, s.sweep_down, s.sweep_step};
            end else if (item.addr == ADDR_NR11) begin
               rdata = {s.duty_sel, 6'h3f};
            end else if (item.addr == ADDR_NR12) begin
               rdata = {s.env_start, s.env_up, s.env_pace};
            end else if (item.addr == ADDR_NR14) begin
               rdata = {1'b1, s.length_on, 6'h3f};
            end
         end
         FUNC_POWER: begin
            s = power_clear(s, item.init_length);
         end
         default: begin
         end
      endcase
      state_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= power_clear(state_ff, 1'b1);
      end else if (item_accept) begin
         state_ff <= state_in;
      end
   end

   assign result.sample     = state_in.level_out;
   assign result.rdata      = rdata;
   assign result.channel_on = state_in.chan_enable;

endmodule

[rtl/pcse_skid.sv]
// two-entry result buffer: output register plus skid register
// depends on pcse_pkg
module pcse_skid import pcse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_stall,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;
   logic    accept;

   assign accept = in_valid && !skid_valid_ff;
   assign take   = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      if (take || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in = in_data;
            main_valid_in = accept;
         end
      end else if (accept) begin
         // output held by receiver, park the new transaction
         skid_in = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

[rtl/pulse_channel_sweep_envelope.sv]
// Square-wave sound channel with frequency sweep, volume envelope and
// length counter, driven by one event per request transaction.
// Request channel (req_valid, req_stall, req_payload): func selects a
// sample tick, length clock, sweep clock, envelope clock, register write,
// register read or power reset; addr, wdata, frame_odd, init_length qualify it.
// Response channel (rsp_valid, rsp_stall, rsp_payload): exactly one
// transaction per request, in order, with the output level, the read data
// (0xff unless a read) and the channel enable after the event.
// The channel state updates at the accepting edge and the response is
// registered. Throughput is one transaction per cycle while req_stall is
// low, set by the single register stage holding the channel state.
// When rsp_stall is high the response waits in the output register and
// one more transaction is taken into a skid register; req_stall rises
// only while that skid register is occupied.
// Synchronous reset clears all channel state, with the length counter
// at 64, and empties both result registers.
// depends on pcse_pkg, pcse_core, pcse_skid and the assertion macro header
`include "pulse_channel_sweep_envelope_assert.svh"

module pulse_channel_sweep_envelope import pcse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    req_accept;
   rsp_type result;

   assign req_accept = req_valid && !req_stall;

   pcse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_accept),
      .item        (req_payload),
      .result      (result)
   );

   pcse_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

   // every accepted transaction leaves the output valid the next cycle
   `PCSE_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid)
   // skid occupied only behind a held output
   `PCSE_ASSERT_SAME(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid)
   // taking a transaction while the output is held fills the skid
   `PCSE_ASSERT_NEXT(a_held_fills_skid, clock, reset,
                     req_accept && rsp_valid && rsp_stall, req_stall)

endmodule
